[sv/sds_pkg.sv]
// Shared types, constants and a helper function for sound direction steering.
package sds_pkg;

	localparam int LEVEL_BITS     = 15;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int THR_BITS       = 16;
	localparam int CMP_BITS       = (LEVEL_BITS > THR_BITS) ? LEVEL_BITS : THR_BITS;
	localparam int PROD_BITS      = LEVEL_BITS + 8;

	// register indexes on the config port
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_THRESHOLD   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_RATIO_Q2     = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FORE_AFT_RATIO_Q2 = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_TICKS        = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TURN_SPEED        = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_SPEED        = 3'd5;

	// request opcodes
	localparam logic OP_EVALUATE = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	typedef struct packed {
		logic [15:0] level_threshold;
		logic [7:0]  side_ratio_q2;
		logic [7:0]  fore_aft_ratio_q2;
		logic [15:0] hold_ticks;
		logic [7:0]  turn_speed;
		logic [7:0]  full_speed;
	} cfg_t;

	typedef struct packed {
		logic                  opcode;
		logic [LEVEL_BITS-1:0] front_level;
		logic [LEVEL_BITS-1:0] left_level;
		logic [LEVEL_BITS-1:0] back_level;
		logic [LEVEL_BITS-1:0] right_level;
	} item_t;

	typedef struct packed {
		logic [7:0] left_speed;
		logic       left_forward;
		logic [7:0] right_speed;
		logic       right_forward;
		logic       motor_updated;
		logic       side_hold;
		logic       fore_aft_hold;
	} result_t;

	// own side wins: 4*own >= ratio*other and own reaches the threshold
	function automatic logic side_wins(
		input logic [LEVEL_BITS-1:0] own,
		input logic [LEVEL_BITS-1:0] other,
		input logic [7:0]            ratio,
		input logic [THR_BITS-1:0]   thr
	);
		logic [PROD_BITS-1:0] own4;
		logic [PROD_BITS-1:0] prod;
		own4 = {6'd0, own, 2'b00};
		prod = PROD_BITS'(other) * PROD_BITS'(ratio);
		return (own4 >= prod) && (CMP_BITS'(own) >= CMP_BITS'(thr));
	endfunction

endpackage

[sv/sds_ifs.sv]
// Handshake channel interfaces: request, result and config write.
interface sds_item_if import sds_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [LEVEL_BITS-1:0] front_level;
	logic [LEVEL_BITS-1:0] left_level;
	logic [LEVEL_BITS-1:0] back_level;
	logic [LEVEL_BITS-1:0] right_level;

	modport source (output valid, opcode, front_level, left_level, back_level, right_level,
		input ready);
	modport sink (input valid, opcode, front_level, left_level, back_level, right_level,
		output ready);
endinterface

interface sds_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] left_speed;
	logic       left_forward;
	logic [7:0] right_speed;
	logic       right_forward;
	logic       motor_updated;
	logic       side_hold;
	logic       fore_aft_hold;

	modport source (output valid, left_speed, left_forward, right_speed, right_forward,
		motor_updated, side_hold, fore_aft_hold, input ready);
	modport sink (input valid, left_speed, left_forward, right_speed, right_forward,
		motor_updated, side_hold, fore_aft_hold, output ready);
endinterface

interface sds_cfg_if import sds_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/sds_cfg.sv]
// Configuration register file written over the config channel.
module sds_cfg import sds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	sds_cfg_if.sink cfg,
	output cfg_t    regs
);
	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.level_threshold   <= 16'd250;
			regs_q.side_ratio_q2     <= 8'd10;
			regs_q.fore_aft_ratio_q2 <= 8'd8;
			regs_q.hold_ticks        <= 16'd100;
			regs_q.turn_speed        <= 8'd128;
			regs_q.full_speed        <= 8'd255;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEVEL_THRESHOLD:   regs_q.level_threshold   <= cfg.data;
				REG_SIDE_RATIO_Q2:     regs_q.side_ratio_q2     <= cfg.data[7:0];
				REG_FORE_AFT_RATIO_Q2: regs_q.fore_aft_ratio_q2 <= cfg.data[7:0];
				REG_HOLD_TICKS:        regs_q.hold_ticks        <= cfg.data;
				REG_TURN_SPEED:        regs_q.turn_speed        <= cfg.data[7:0];
				REG_FULL_SPEED:        regs_q.full_speed        <= cfg.data[7:0];
				default: ;
			endcase
		end
	end
endmodule

[sv/sds_steer.sv]
// Steering state: confirm counters, holds, hold timer and motor command.
module sds_steer import sds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    regs,
	output result_t nxt
);
	logic [1:0]  front_q, left_q, back_q, right_q;
	logic        side_hold_q, fa_hold_q;
	logic [15:0] hold_count_q;
	logic        hold_running_q;
	logic [7:0]  lspd_q, rspd_q;
	logic        lfwd_q, rfwd_q;

	logic [1:0]  front_d, left_d, back_d, right_d;
	logic        side_hold_d, fa_hold_d;
	logic [15:0] hold_count_d, limit, count_inc;
	logic        hold_running_d;
	logic [7:0]  lspd_d, rspd_d;
	logic        lfwd_d, rfwd_d, updated;
	logic        l_win, r_win, f_win, b_win, lr_win, fb_win;
	logic [1:0]  l_inc, r_inc, f_inc, b_inc;

	always_comb begin
		l_win = side_wins(item.left_level, item.right_level, regs.side_ratio_q2,
			regs.level_threshold);
		r_win = side_wins(item.right_level, item.left_level, regs.side_ratio_q2,
			regs.level_threshold);
		f_win = side_wins(item.front_level, item.back_level, regs.fore_aft_ratio_q2,
			regs.level_threshold);
		b_win = side_wins(item.back_level, item.front_level, regs.fore_aft_ratio_q2,
			regs.level_threshold);
		l_inc = left_q + 2'd1;
		r_inc = right_q + 2'd1;
		f_inc = front_q + 2'd1;
		b_inc = back_q + 2'd1;
		limit = (regs.hold_ticks == 16'd0) ? 16'd1 : regs.hold_ticks;
		count_inc = hold_count_q + 16'd1;

		front_d = front_q; left_d = left_q; back_d = back_q; right_d = right_q;
		side_hold_d = side_hold_q; fa_hold_d = fa_hold_q;
		hold_count_d = hold_count_q; hold_running_d = hold_running_q;
		lspd_d = lspd_q; rspd_d = rspd_q; lfwd_d = lfwd_q; rfwd_d = rfwd_q;
		updated = 1'b0; lr_win = 1'b0; fb_win = 1'b0;

		if (item.opcode == OP_EVALUATE) begin
			if (!side_hold_q) begin
				if (l_win) begin
					lr_win = 1'b1;
					right_d = 2'd0;
					left_d = l_inc;
					if (l_inc > 2'd1) begin
						lspd_d = regs.turn_speed; lfwd_d = 1'b1;
						rspd_d = regs.full_speed; rfwd_d = 1'b1;
						updated = 1'b1; left_d = 2'd0;
					end
				end else if (r_win) begin
					lr_win = 1'b1;
					left_d = 2'd0;
					right_d = r_inc;
					if (r_inc > 2'd1) begin
						lspd_d = regs.full_speed; lfwd_d = 1'b1;
						rspd_d = regs.turn_speed; rfwd_d = 1'b1;
						updated = 1'b1; right_d = 2'd0;
					end
				end
			end
			// front/back applied after left/right so it overrides
			if (!fa_hold_q) begin
				if (f_win) begin
					fb_win = 1'b1;
					back_d = 2'd0;
					front_d = f_inc;
					if (f_inc > 2'd1) begin
						lspd_d = regs.full_speed; lfwd_d = 1'b1;
						rspd_d = regs.full_speed; rfwd_d = 1'b1;
						updated = 1'b1; front_d = 2'd0;
					end
				end else if (b_win) begin
					fb_win = 1'b1;
					front_d = 2'd0;
					back_d = b_inc;
					if (b_inc > 2'd2) begin
						lspd_d = regs.full_speed; lfwd_d = 1'b0;
						rspd_d = regs.full_speed; rfwd_d = 1'b0;
						updated = 1'b1; back_d = 2'd0;
					end
				end
			end
			if (lr_win) side_hold_d = 1'b1;
			if (fb_win) fa_hold_d = 1'b1;
			if (lr_win || fb_win) begin
				hold_count_d = 16'd0;
				hold_running_d = 1'b1;
			end
		end else if (hold_running_q) begin
			hold_count_d = count_inc;
			if (count_inc >= limit) begin
				side_hold_d = 1'b0;
				fa_hold_d = 1'b0;
				hold_running_d = 1'b0;
				hold_count_d = 16'd0;
			end
		end

		nxt.left_speed    = lspd_d;
		nxt.left_forward  = lfwd_d;
		nxt.right_speed   = rspd_d;
		nxt.right_forward = rfwd_d;
		nxt.motor_updated = updated;
		nxt.side_hold     = side_hold_d;
		nxt.fore_aft_hold = fa_hold_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= 2'd0; left_q <= 2'd0; back_q <= 2'd0; right_q <= 2'd0;
			side_hold_q <= 1'b0; fa_hold_q <= 1'b0;
			hold_count_q <= 16'd0; hold_running_q <= 1'b0;
			lspd_q <= 8'd0; rspd_q <= 8'd0; lfwd_q <= 1'b0; rfwd_q <= 1'b0;
		end else if (fire) begin
			front_q <= front_d; left_q <= left_d; back_q <= back_d; right_q <= right_d;
			side_hold_q <= side_hold_d; fa_hold_q <= fa_hold_d;
			hold_count_q <= hold_count_d; hold_running_q <= hold_running_d;
			lspd_q <= lspd_d; rspd_q <= rspd_d; lfwd_q <= lfwd_d; rfwd_q <= rfwd_d;
		end
	end
endmodule

[sv/sound_direction_steering.sv]
// Sound direction steering top level: request register, steering logic, result register.
// Each request is either an evaluate (four microphone loudness levels) or a hold-timer tick,
// and produces exactly one result with the motor command, a motor-updated flag and both hold
// flags. A request is taken into an input register, judged against the steering state, and
// the result lands in an output register; one request per clock is sustained while results
// are taken. The state update (confirm counters, holds, timer) is made as each request moves
// on, so back-to-back requests always see the state left by the one before. When the result
// register is full and not taken, the input register stalls; the input register still
// accepts while the result waits as long as it is empty. Config writes are taken on every
// cycle and should be issued only while no request is in flight.
module sound_direction_steering import sds_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sds_item_if.sink      item,
	sds_result_if.source  result,
	sds_cfg_if.sink       cfg
);
	cfg_t    regs;
	item_t   item_s1;
	logic    valid_s1;
	result_t nxt;
	result_t result_s2;
	logic    valid_s2;
	logic    advance, fire;

	// stage 2 frees up when empty or being drained this cycle
	assign advance    = !valid_s2 || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	sds_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sds_steer u_steer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.regs   (regs),
		.nxt    (nxt)
	);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.opcode      <= item.opcode;
			item_s1.front_level <= item.front_level;
			item_s1.left_level  <= item.left_level;
			item_s1.back_level  <= item.back_level;
			item_s1.right_level <= item.right_level;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= nxt;
		end
	end

	assign result.valid         = valid_s2;
	assign result.left_speed    = result_s2.left_speed;
	assign result.left_forward  = result_s2.left_forward;
	assign result.right_speed   = result_s2.right_speed;
	assign result.right_forward = result_s2.right_forward;
	assign result.motor_updated = result_s2.motor_updated;
	assign result.side_hold     = result_s2.side_hold;
	assign result.fore_aft_hold = result_s2.fore_aft_hold;
endmodule
